>>> src/df1_pkg.sv
// ----------------------------------------------------------------------------
// df1_pkg: shared types, codes and microcode for the DF1 frame builder
// Holds the request/frame beat types, the byte-source and sequencer op
// codes, and the read-only microprogram that walks one frame.
// ----------------------------------------------------------------------------
package df1_pkg;

	// Request and frame beats
	typedef struct packed {
		logic [1:0]  kind;
		logic [7:0]  station;
		logic [15:0] address;
		logic [9:0]  file_num;
		logic [6:0]  word_count;
		logic [15:0] write_value;
		logic        bit_value;
	} df1_req_t;

	typedef struct packed {
		logic [7:0] tx_byte;
		logic       last_byte;
	} df1_frame_t;

	// Request kinds
	localparam logic [1:0] KIND_READ  = 2'd0;
	localparam logic [1:0] KIND_WRITE = 2'd1;
	localparam logic [1:0] KIND_BIT   = 2'd2;
	localparam logic [1:0] KIND_NONE  = 2'd3;

	// Frame bytes
	localparam logic [7:0] DLE_BYTE   = 8'h10;
	localparam logic [7:0] STX_BYTE   = 8'h02;
	localparam logic [7:0] ETX_BYTE   = 8'h03;
	localparam logic [7:0] ZERO_BYTE  = 8'h00;
	localparam logic [7:0] CMD_BYTE   = 8'h0F;
	localparam logic [7:0] FNC_READ   = 8'h01;
	localparam logic [7:0] FNC_WRITE  = 8'h00;
	localparam logic [7:0] FNC_BIT    = 8'h26;
	localparam logic [7:0] FILE_TYPE  = 8'h06;
	localparam logic [7:0] SHORT_FORM = 8'h07;
	localparam logic [7:0] LONG_MARK  = 8'hFF;

	localparam int NUM_KINDS = 3;
	localparam int PC_W      = 6;

	// Byte sources of the datapath
	typedef enum logic [4:0] {
		SRC_CONST   = 5'd0,
		SRC_STATION = 5'd1,
		SRC_TNS_LO  = 5'd2,
		SRC_TNS_HI  = 5'd3,
		SRC_ADDR_LO = 5'd4,
		SRC_ADDR_HI = 5'd5,
		SRC_END_LO  = 5'd6,
		SRC_END_HI  = 5'd7,
		SRC_FILE_LO = 5'd8,
		SRC_FILE_HI = 5'd9,
		SRC_CNT2    = 5'd10,
		SRC_VAL_LO  = 5'd11,
		SRC_VAL_HI  = 5'd12,
		SRC_WIDX_LO = 5'd13,
		SRC_WIDX_HI = 5'd14,
		SRC_AND_LO  = 5'd15,
		SRC_AND_HI  = 5'd16,
		SRC_OR_LO   = 5'd17,
		SRC_OR_HI   = 5'd18,
		SRC_CHECK   = 5'd19
	} df1_src_t;

	// Sequencer ops
	typedef enum logic [2:0] {
		OP_NEXT     = 3'd0,
		OP_DISPATCH = 3'd1,
		OP_SHORT    = 3'd2,
		OP_JUMP     = 3'd3,
		OP_END      = 3'd4
	} df1_op_t;

	// One microcode word
	typedef struct packed {
		df1_src_t         src;
		logic [7:0]       imm;
		logic             body;
		logic             last;
		df1_op_t          op;
		logic [PC_W-1:0]  target;
	} df1_uword_t;

	// Sequencer to datapath
	typedef struct packed {
		logic       emit;
		logic       dup;
		df1_src_t   src;
		logic [7:0] imm;
		logic       body;
		logic       last;
	} df1_ctrl_t;

	// Datapath to sequencer
	typedef struct packed {
		logic       out_free;
		logic       long_addr;
		logic       dle_hit;
		logic [1:0] kind;
	} df1_stat_t;

	// Program entry points
	localparam logic [PC_W-1:0] PC_READ  = 6'd8;
	localparam logic [PC_W-1:0] PC_WRITE = 6'd17;
	localparam logic [PC_W-1:0] PC_BIT   = 6'd27;
	localparam logic [PC_W-1:0] PC_SHORT = 6'd33;
	localparam logic [PC_W-1:0] PC_MASK  = 6'd37;
	localparam logic [PC_W-1:0] PC_TRAIL = 6'd41;

	function automatic df1_uword_t df1_uw(df1_src_t src, logic [7:0] imm, logic body,
			logic last, df1_op_t op, logic [PC_W-1:0] target);
		df1_uword_t w;
		w.src    = src;
		w.imm    = imm;
		w.body   = body;
		w.last   = last;
		w.op     = op;
		w.target = target;
		return w;
	endfunction

	// Microprogram: header, per-kind body, trailer
	function automatic df1_uword_t df1_urom(logic [PC_W-1:0] pc);
		df1_uword_t w;
		case (pc)
			// header
			6'd0:  w = df1_uw(SRC_CONST, DLE_BYTE, 1'b0, 1'b0, OP_NEXT, '0);
			6'd1:  w = df1_uw(SRC_CONST, STX_BYTE, 1'b0, 1'b0, OP_NEXT, '0);
			6'd2:  w = df1_uw(SRC_STATION, ZERO_BYTE, 1'b1, 1'b0, OP_NEXT, '0);
			6'd3:  w = df1_uw(SRC_CONST, ZERO_BYTE, 1'b1, 1'b0, OP_NEXT, '0);
			6'd4:  w = df1_uw(SRC_CONST, CMD_BYTE, 1'b1, 1'b0, OP_NEXT, '0);
			6'd5:  w = df1_uw(SRC_CONST, ZERO_BYTE, 1'b1, 1'b0, OP_NEXT, '0);
			6'd6:  w = df1_uw(SRC_TNS_LO, ZERO_BYTE, 1'b1, 1'b0, OP_NEXT, '0);
			6'd7:  w = df1_uw(SRC_TNS_HI, ZERO_BYTE, 1'b1, 1'b0, OP_DISPATCH, '0);
			// block read
			6'd8:  w = df1_uw(SRC_CONST, FNC_READ, 1'b1, 1'b0, OP_NEXT, '0);
			6'd9:  w = df1_uw(SRC_ADDR_LO, ZERO_BYTE, 1'b1, 1'b0, OP_NEXT, '0);
			6'd10: w = df1_uw(SRC_ADDR_HI, ZERO_BYTE, 1'b1, 1'b0, OP_NEXT, '0);
			6'd11: w = df1_uw(SRC_END_LO, ZERO_BYTE, 1'b1, 1'b0, OP_NEXT, '0);
			6'd12: w = df1_uw(SRC_END_HI, ZERO_BYTE, 1'b1, 1'b0, OP_NEXT, '0);
			6'd13: w = df1_uw(SRC_CONST, FILE_TYPE, 1'b1, 1'b0, OP_NEXT, '0);
			6'd14: w = df1_uw(SRC_FILE_LO, ZERO_BYTE, 1'b1, 1'b0, OP_NEXT, '0);
			6'd15: w = df1_uw(SRC_FILE_HI, ZERO_BYTE, 1'b1, 1'b0, OP_NEXT, '0);
			6'd16: w = df1_uw(SRC_CNT2, ZERO_BYTE, 1'b1, 1'b0, OP_JUMP, PC_TRAIL);
			// word write
			6'd17: w = df1_uw(SRC_CONST, FNC_WRITE, 1'b1, 1'b0, OP_NEXT, '0);
			6'd18: w = df1_uw(SRC_ADDR_LO, ZERO_BYTE, 1'b1, 1'b0, OP_NEXT, '0);
			6'd19: w = df1_uw(SRC_ADDR_HI, ZERO_BYTE, 1'b1, 1'b0, OP_NEXT, '0);
			6'd20: w = df1_uw(SRC_END_LO, ZERO_BYTE, 1'b1, 1'b0, OP_NEXT, '0);
			6'd21: w = df1_uw(SRC_END_HI, ZERO_BYTE, 1'b1, 1'b0, OP_NEXT, '0);
			6'd22: w = df1_uw(SRC_CONST, FILE_TYPE, 1'b1, 1'b0, OP_NEXT, '0);
			6'd23: w = df1_uw(SRC_FILE_LO, ZERO_BYTE, 1'b1, 1'b0, OP_NEXT, '0);
			6'd24: w = df1_uw(SRC_FILE_HI, ZERO_BYTE, 1'b1, 1'b0, OP_NEXT, '0);
			6'd25: w = df1_uw(SRC_VAL_LO, ZERO_BYTE, 1'b1, 1'b0, OP_NEXT, '0);
			6'd26: w = df1_uw(SRC_VAL_HI, ZERO_BYTE, 1'b1, 1'b0, OP_JUMP, PC_TRAIL);
			// bit write, long address form
			6'd27: w = df1_uw(SRC_CONST, FNC_BIT, 1'b1, 1'b0, OP_SHORT, PC_SHORT);
			6'd28: w = df1_uw(SRC_CONST, FILE_TYPE, 1'b1, 1'b0, OP_NEXT, '0);
			6'd29: w = df1_uw(SRC_FILE_LO, ZERO_BYTE, 1'b1, 1'b0, OP_NEXT, '0);
			6'd30: w = df1_uw(SRC_CONST, LONG_MARK, 1'b1, 1'b0, OP_NEXT, '0);
			6'd31: w = df1_uw(SRC_WIDX_LO, ZERO_BYTE, 1'b1, 1'b0, OP_NEXT, '0);
			6'd32: w = df1_uw(SRC_WIDX_HI, ZERO_BYTE, 1'b1, 1'b0, OP_JUMP, PC_MASK);
			// bit write, short address form
			6'd33: w = df1_uw(SRC_CONST, SHORT_FORM, 1'b1, 1'b0, OP_NEXT, '0);
			6'd34: w = df1_uw(SRC_CONST, ZERO_BYTE, 1'b1, 1'b0, OP_NEXT, '0);
			6'd35: w = df1_uw(SRC_FILE_LO, ZERO_BYTE, 1'b1, 1'b0, OP_NEXT, '0);
			6'd36: w = df1_uw(SRC_WIDX_LO, ZERO_BYTE, 1'b1, 1'b0, OP_NEXT, '0);
			// bit write masks
			6'd37: w = df1_uw(SRC_AND_LO, ZERO_BYTE, 1'b1, 1'b0, OP_NEXT, '0);
			6'd38: w = df1_uw(SRC_AND_HI, ZERO_BYTE, 1'b1, 1'b0, OP_NEXT, '0);
			6'd39: w = df1_uw(SRC_OR_LO, ZERO_BYTE, 1'b1, 1'b0, OP_NEXT, '0);
			6'd40: w = df1_uw(SRC_OR_HI, ZERO_BYTE, 1'b1, 1'b0, OP_NEXT, '0);
			// trailer
			6'd41: w = df1_uw(SRC_CONST, DLE_BYTE, 1'b0, 1'b0, OP_NEXT, '0);
			6'd42: w = df1_uw(SRC_CONST, ETX_BYTE, 1'b0, 1'b0, OP_NEXT, '0);
			6'd43: w = df1_uw(SRC_CHECK, ZERO_BYTE, 1'b0, 1'b1, OP_END, '0);
			default: w = df1_uw(SRC_CHECK, ZERO_BYTE, 1'b0, 1'b1, OP_END, '0);
		endcase
		return w;
	endfunction

endpackage

>>> src/df1_seq.sv
// ----------------------------------------------------------------------------
// df1_seq: microcode sequencer
// Step counter over the microprogram ROM; inserts the doubled DLE copy and
// takes the kind dispatch and address-form branch.
// ----------------------------------------------------------------------------
module df1_seq (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	input  df1_pkg::df1_stat_t  stat,
	output logic                busy,
	output df1_pkg::df1_ctrl_t  ctrl
);

	logic                     busy_q;
	logic                     dup_q;
	logic [df1_pkg::PC_W-1:0] pc_q;
	df1_pkg::df1_uword_t      uw;
	logic                     step;
	logic [df1_pkg::PC_W-1:0] entry;

	assign uw   = df1_pkg::df1_urom(pc_q);
	assign step = busy_q && stat.out_free;
	assign busy = busy_q;

	// Pick the body entry for the latched kind
	always_comb begin
		case (stat.kind)
			df1_pkg::KIND_READ:  entry = df1_pkg::PC_READ;
			df1_pkg::KIND_WRITE: entry = df1_pkg::PC_WRITE;
			default:             entry = df1_pkg::PC_BIT;
		endcase
	end

	// Drive the datapath from the current word
	always_comb begin
		ctrl.emit = step;
		ctrl.dup  = dup_q;
		ctrl.src  = uw.src;
		ctrl.imm  = uw.imm;
		ctrl.body = uw.body;
		ctrl.last = uw.last;
	end

	// Advance the step counter, hold it while a DLE copy goes out
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			dup_q  <= 1'b0;
			pc_q   <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			dup_q  <= 1'b0;
			pc_q   <= '0;
		end else if (step) begin
			if (dup_q) begin
				dup_q <= 1'b0;
			end else begin
				dup_q <= uw.body && stat.dle_hit;
				case (uw.op)
					df1_pkg::OP_NEXT:     pc_q <= pc_q + 1'b1;
					df1_pkg::OP_DISPATCH: pc_q <= entry;
					df1_pkg::OP_SHORT:    pc_q <= stat.long_addr ? pc_q + 1'b1 : uw.target;
					df1_pkg::OP_JUMP:     pc_q <= uw.target;
					df1_pkg::OP_END:      busy_q <= 1'b0;
					default:              pc_q <= pc_q + 1'b1;
				endcase
			end
		end
	end

endmodule

>>> src/df1_dp.sv
// ----------------------------------------------------------------------------
// df1_dp: frame datapath
// Request registers, per-kind transaction counters, byte source mux,
// block check sum and the output beat register.
// ----------------------------------------------------------------------------
module df1_dp (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                load,
	input  df1_pkg::df1_req_t   req,
	input  df1_pkg::df1_ctrl_t  ctrl,
	output df1_pkg::df1_stat_t  stat,
	input  logic                frame_stall,
	output logic                frame_valid,
	output df1_pkg::df1_frame_t frame
);

	df1_pkg::df1_req_t   req_q;
	logic [15:0]         tns_q;
	logic [15:0]         end_q;
	logic [15:0]         cnt_q [df1_pkg::NUM_KINDS];
	logic [7:0]          sum_q;
	logic                out_valid_q;
	df1_pkg::df1_frame_t out_q;

	logic [7:0]  sel_byte;
	logic [11:0] widx;
	logic [15:0] bit_mask;
	logic [15:0] keep_mask;
	logic [15:0] or_mask;
	logic [15:0] cnt_next;

	assign widx      = req_q.address[15:4];
	assign bit_mask  = 16'd1 << req_q.address[3:0];
	assign keep_mask = req_q.bit_value ? 16'hFFFF : ~bit_mask;
	assign or_mask   = req_q.bit_value ? bit_mask : 16'h0000;
	assign cnt_next  = cnt_q[req.kind] + 16'd1;

	// Select the frame byte for this step
	always_comb begin
		case (ctrl.src)
			df1_pkg::SRC_CONST:   sel_byte = ctrl.imm;
			df1_pkg::SRC_STATION: sel_byte = req_q.station;
			df1_pkg::SRC_TNS_LO:  sel_byte = tns_q[7:0];
			df1_pkg::SRC_TNS_HI:  sel_byte = tns_q[15:8];
			df1_pkg::SRC_ADDR_LO: sel_byte = req_q.address[7:0];
			df1_pkg::SRC_ADDR_HI: sel_byte = req_q.address[15:8];
			df1_pkg::SRC_END_LO:  sel_byte = end_q[7:0];
			df1_pkg::SRC_END_HI:  sel_byte = end_q[15:8];
			df1_pkg::SRC_FILE_LO: sel_byte = req_q.file_num[7:0];
			df1_pkg::SRC_FILE_HI: sel_byte = {6'd0, req_q.file_num[9:8]};
			df1_pkg::SRC_CNT2:    sel_byte = {req_q.word_count, 1'b0};
			df1_pkg::SRC_VAL_LO:  sel_byte = req_q.write_value[7:0];
			df1_pkg::SRC_VAL_HI:  sel_byte = req_q.write_value[15:8];
			df1_pkg::SRC_WIDX_LO: sel_byte = widx[7:0];
			df1_pkg::SRC_WIDX_HI: sel_byte = {4'd0, widx[11:8]};
			df1_pkg::SRC_AND_LO:  sel_byte = keep_mask[7:0];
			df1_pkg::SRC_AND_HI:  sel_byte = keep_mask[15:8];
			df1_pkg::SRC_OR_LO:   sel_byte = or_mask[7:0];
			df1_pkg::SRC_OR_HI:   sel_byte = or_mask[15:8];
			df1_pkg::SRC_CHECK:   sel_byte = 8'd0 - sum_q;
			default:              sel_byte = ctrl.imm;
		endcase
	end

	always_comb begin
		stat.out_free  = !out_valid_q || !frame_stall;
		stat.long_addr = |widx[11:8];
		stat.dle_hit   = (sel_byte == df1_pkg::DLE_BYTE);
		stat.kind      = req_q.kind;
	end

	// Latch the request and bump its transaction counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < df1_pkg::NUM_KINDS; i++) begin
				cnt_q[i] <= '0;
			end
		end else if (load && req.kind != df1_pkg::KIND_NONE) begin
			cnt_q[req.kind] <= cnt_next;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			req_q <= req;
			tns_q <= cnt_next;
			if (req.kind == df1_pkg::KIND_READ) begin
				end_q <= req.address + {9'd0, req.word_count};
			end else begin
				end_q <= req.address + 16'd1;
			end
		end
	end

	// Accumulate the check sum over the body-flagged bytes (station onward), once each
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q <= '0;
		end else if (load) begin
			sum_q <= '0;
		end else if (ctrl.emit && !ctrl.dup && ctrl.body) begin
			sum_q <= sum_q + sel_byte;
		end
	end

	// Output beat register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (ctrl.emit) begin
			out_valid_q <= 1'b1;
		end else if (!frame_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.emit) begin
			out_q.tx_byte   <= ctrl.dup ? df1_pkg::DLE_BYTE : sel_byte;
			out_q.last_byte <= ctrl.dup ? 1'b0 : ctrl.last;
		end
	end

	assign frame_valid = out_valid_q;
	assign frame       = out_q;

endmodule

>>> src/df1_command_frame_builder.sv
// ----------------------------------------------------------------------------
// df1_command_frame_builder: DF1 command frame builder with block check
// Turns one read, word write or bit write request into its serial frame,
// one byte per beat, ending in the block check byte.
// ----------------------------------------------------------------------------
// The first byte follows the request via the step counter and output register.
// One frame byte per cycle while the output is not stalled; a frame has 20
// bytes or more, and the next request waits until the check byte is issued.
// A request of unused kind 3 is accepted and produces no frame.
// Reset clears the transaction counters, sequencer and output valid.
module df1_command_frame_builder (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                req_valid,
	output logic                req_stall,
	input  df1_pkg::df1_req_t   req,
	output logic                frame_valid,
	input  logic                frame_stall,
	output df1_pkg::df1_frame_t frame
);

	logic               busy;
	logic               accept;
	logic               start;
	df1_pkg::df1_ctrl_t ctrl;
	df1_pkg::df1_stat_t stat;

	// Take a request only while no frame is in progress
	assign req_stall = busy;
	assign accept    = req_valid && !busy;
	assign start     = accept && (req.kind != df1_pkg::KIND_NONE);

	df1_seq u_seq (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.stat   (stat),
		.busy   (busy),
		.ctrl   (ctrl)
	);

	df1_dp u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.load        (accept),
		.req         (req),
		.ctrl        (ctrl),
		.stat        (stat),
		.frame_stall (frame_stall),
		.frame_valid (frame_valid),
		.frame       (frame)
	);

endmodule

>>> src/df1_chk.sv
// ----------------------------------------------------------------------------
// df1_chk: port checker for the DF1 frame builder
// Watches the request and frame channels and the busy window between them.
// ----------------------------------------------------------------------------
module df1_chk (
	input logic                clk,
	input logic                arst_n,
	input logic                req_valid,
	input logic                req_stall,
	input df1_pkg::df1_req_t   req,
	input logic                frame_valid,
	input logic                frame_stall,
	input df1_pkg::df1_frame_t frame
);

	// A stalled frame beat holds
	a_frame_hold: assert property (@(posedge clk) disable iff (!arst_n)
		frame_valid && frame_stall |=> frame_valid && $stable(frame))
		else $error("frame beat changed while stalled");

	// A real request closes the request side for its frame
	a_busy_after_req: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && !req_stall && req.kind != df1_pkg::KIND_NONE |=> req_stall)
		else $error("request side open right after a request");

	// An unused kind leaves the request side open
	a_drop_unused: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && !req_stall && req.kind == df1_pkg::KIND_NONE |=> !req_stall)
		else $error("unused kind started a frame");

	// The request side reopens exactly as the check byte is loaded
	a_end_on_check: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(req_stall) |-> frame_valid && frame.last_byte)
		else $error("frame ended without a check byte");

endmodule

bind df1_command_frame_builder df1_chk u_chk (.*);
